// ===== rtl/core/fbpa_pkg.sv =====
// Shared types and constants for the fixed block pool allocator.
// No dependencies; imported by fixed_block_pool_allocator.
`default_nettype none

package fbpa_pkg;

  // Request kinds carried in the input word
  typedef enum logic [1:0] {
    OP_GET   = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_OVERFREE  = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_e;

  // Configuration register indexes
  localparam logic REG_BAR_COUNT = 1'b0;
  localparam logic REG_BAR_WIDTH = 1'b1;

  // Field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned BAR_W    = 4;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned CNT_OUT_W = 11;
  localparam int unsigned HANDLE_W = BAR_W + SLOT_W;
  localparam int unsigned BAR_COUNT_W = 5;
  localparam int unsigned BAR_WIDTH_W = 7;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 48;

  // Register reset values and clamp floors
  localparam logic [BAR_COUNT_W-1:0] BAR_COUNT_RST = 5'd16;
  localparam logic [BAR_WIDTH_W-1:0] BAR_WIDTH_RST = 7'd64;
  localparam int unsigned MIN_BAR_COUNT = 2;
  localparam int unsigned MIN_BAR_WIDTH = 5;

endpackage

`default_nettype wire

// ===== rtl/core/fixed_block_pool_allocator.sv =====
// Fixed block pool allocator: bump pointer plus a LIFO free stack held in one
// synchronous memory with a registered read.
// The result word is registered when execute commits (accept, then execute);
// execute holds while the previous result word still waits downstream.
// A new request is taken only after the previous one has executed.
// Reset (rst_ni low, async) clears counters and pointers, not the stack memory.
`default_nettype none

module fixed_block_pool_allocator #(
  parameter int unsigned MAX_BARS  = 16,
  parameter int unsigned MAX_WIDTH = 64
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // cfg_index_i: 0 bar_count, 1 bar_width
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire                                   cfg_index_i,
  input  wire  [fbpa_pkg::BAR_WIDTH_W-1:0]      cfg_data_i,
  // s_axis_tdata_i: [1:0] op, [5:2] free_bar, [11:6] free_slot, rest zero
  input  wire                                   s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire  [fbpa_pkg::IN_TDATA_W-1:0]       s_axis_tdata_i,
  // m_axis_tdata_o: [1:0] status, [5:2] bar_index, [11:6] slot_index,
  // [22:12] in_use, [33:23] on_list, [44:34] fresh_taken, rest zero
  output logic                                  m_axis_tvalid_o,
  input  wire                                   m_axis_tready_i,
  output logic [fbpa_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o
);

  import fbpa_pkg::*;

  localparam int unsigned Depth = MAX_BARS * MAX_WIDTH;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned BarW  = $clog2(MAX_BARS + 1);
  localparam int unsigned SlotW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned BcW   = (BarW > BAR_COUNT_W) ? BarW : BAR_COUNT_W;
  localparam int unsigned WcW   = (SlotW > BAR_WIDTH_W) ? SlotW : BAR_WIDTH_W;

  // Configuration
  logic [BAR_COUNT_W-1:0] bar_count_q;
  logic [BAR_WIDTH_W-1:0] bar_width_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_count_q <= BAR_COUNT_RST;
      bar_width_q <= BAR_WIDTH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_BAR_COUNT) begin
        bar_count_q <= cfg_data_i[BAR_COUNT_W-1:0];
      end else begin
        bar_width_q <= cfg_data_i;
      end
    end
  end

  // Clamp the registers into the supported range
  logic [BcW-1:0]   bc_ext;
  logic [WcW-1:0]   wc_ext;
  logic [BarW-1:0]  bars;
  logic [SlotW-1:0] width;

  always_comb begin
    bc_ext = BcW'(bar_count_q);
    wc_ext = WcW'(bar_width_q);
    priority if (bc_ext < BcW'(MIN_BAR_COUNT)) begin
      bars = BarW'(MIN_BAR_COUNT);
    end else if (bc_ext > BcW'(MAX_BARS)) begin
      bars = BarW'(MAX_BARS);
    end else begin
      bars = BarW'(bc_ext);
    end
    priority if (wc_ext < WcW'(MIN_BAR_WIDTH)) begin
      width = SlotW'(MIN_BAR_WIDTH);
    end else if (wc_ext > WcW'(MAX_WIDTH)) begin
      width = SlotW'(MAX_WIDTH);
    end else begin
      width = SlotW'(wc_ext);
    end
  end

  // Sequencer and request holding registers
  fsm_e              state_q, state_d;
  op_e               req_op_q;
  logic [BAR_W-1:0]  req_bar_q;
  logic [SLOT_W-1:0] req_slot_q;
  logic              in_acc;
  logic              commit;

  // Allocator state
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  in_use_q, in_use_d;
  logic [CntW-1:0]  fresh_q, fresh_d;
  logic [BarW-1:0]  cur_bar_q, cur_bar_d;
  logic [SlotW-1:0] cur_slot_q, cur_slot_d;

  // Output register
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic [OUT_TDATA_W-1:0] res_data;

  // Free stack memory
  logic [HANDLE_W-1:0] stack_mem [Depth];
  logic [HANDLE_W-1:0] rd_data_q;
  logic [AddrW-1:0]    rd_addr;
  logic                wr_en;
  logic                push;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign commit          = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready_i);
  assign rd_addr         = AddrW'(count_q - CntW'(1));
  assign wr_en           = push && commit;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_data_q <= stack_mem[rd_addr];
    end
    if (wr_en) begin
      stack_mem[AddrW'(count_q)] <= {req_bar_q, req_slot_q};
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_EXEC;
      S_EXEC: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Execute: compute the result and the state update
  status_e           status;
  logic [BAR_W-1:0]  gbar;
  logic [SLOT_W-1:0] gslot;
  logic              roll;
  logic [BarW-1:0]   nb;
  logic [SlotW-1:0]  ns;

  always_comb begin
    count_d    = count_q;
    in_use_d   = in_use_q;
    fresh_d    = fresh_q;
    cur_bar_d  = cur_bar_q;
    cur_slot_d = cur_slot_q;
    status     = STAT_OK;
    gbar       = '0;
    gslot      = '0;
    push       = 1'b0;
    roll       = (cur_slot_q >= width);
    nb         = roll ? (cur_bar_q + BarW'(1)) : cur_bar_q;
    ns         = roll ? '0 : cur_slot_q;
    unique case (req_op_q)
      OP_GET: begin
        if (count_q != '0) begin
          count_d  = count_q - CntW'(1);
          gbar     = rd_data_q[HANDLE_W-1:SLOT_W];
          gslot    = rd_data_q[SLOT_W-1:0];
          in_use_d = in_use_q + CntW'(1);
        end else if (nb >= bars) begin
          status = STAT_EXHAUSTED;
        end else begin
          gbar       = BAR_W'(nb);
          gslot      = SLOT_W'(ns);
          cur_bar_d  = nb;
          cur_slot_d = ns + SlotW'(1);
          in_use_d   = in_use_q + CntW'(1);
          fresh_d    = fresh_q + CntW'(1);
        end
      end
      OP_FREE: begin
        if (in_use_q == '0) begin
          status = STAT_OVERFREE;
        end else if (count_q >= CntW'(Depth)) begin
          status = STAT_FULL;
        end else begin
          push     = 1'b1;
          count_d  = count_q + CntW'(1);
          in_use_d = in_use_q - CntW'(1);
        end
      end
      OP_CLEAR: begin
        count_d    = '0;
        in_use_d   = '0;
        fresh_d    = '0;
        cur_bar_d  = '0;
        cur_slot_d = '0;
      end
      OP_NONE: ;
      default: ;
    endcase
    res_data = {3'b000,
                CNT_OUT_W'(fresh_d),
                CNT_OUT_W'(count_d),
                CNT_OUT_W'(in_use_d),
                gslot, gbar, status};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      in_use_q    <= '0;
      fresh_q     <= '0;
      cur_bar_q   <= '0;
      cur_slot_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        count_q     <= count_d;
        in_use_q    <= in_use_d;
        fresh_q     <= fresh_d;
        cur_bar_q   <= cur_bar_d;
        cur_slot_q  <= cur_slot_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_op_q   <= op_e'(s_axis_tdata_i[OP_W-1:0]);
      req_bar_q  <= s_axis_tdata_i[OP_W+BAR_W-1:OP_W];
      req_slot_q <= s_axis_tdata_i[OP_W+BAR_W+SLOT_W-1:OP_W+BAR_W];
    end
    if (commit) begin
      out_data_q <= res_data;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // Every block handed out is either still in use or back on the stack
  a_conserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CntW'(count_q + in_use_q) == fresh_q))
    else $error("stack count plus in-use count differs from fresh count");

  // Bump pointer never walks past the last bar
  a_bar_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_bar_q < BarW'(MAX_BARS)))
    else $error("bump pointer beyond last bar");

  // An accepted request blocks intake while execute runs
  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("second request accepted during execute");

  // A new result word only follows an execute cycle
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_EXEC))
    else $error("result word without execute");
`endif

endmodule

`default_nettype wire

// ===== verif/fbpa_checker.sv =====
`timescale 1ns / 100ps
// Checker for the fixed block pool allocator: tracks register writes, predicts
// one result word per accepted request and compares field by field. Uses fbpa_pkg.
module fbpa_checker #(
  parameter int unsigned MAX_BARS  = 16,
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic                             cfg_index_i,
  input  logic [fbpa_pkg::BAR_WIDTH_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  // in_data_i: [1:0] op, [5:2] free_bar, [11:6] free_slot
  input  logic [fbpa_pkg::IN_TDATA_W-1:0]  in_data_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  // out_data_i: [1:0] status, [5:2] bar_index, [11:6] slot_index,
  // [22:12] in_use, [33:23] on_list, [44:34] fresh_taken
  input  logic [fbpa_pkg::OUT_TDATA_W-1:0] out_data_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               words_checked_o
);
  import fbpa_pkg::*;

  localparam int unsigned STACK_DEPTH = MAX_BARS * MAX_WIDTH;
  localparam int unsigned MAX_PRINTS  = 40;

  typedef struct packed {
    status_e              status;
    logic [BAR_W-1:0]     bar;
    logic [SLOT_W-1:0]    slot;
    logic [CNT_OUT_W-1:0] in_use;
    logic [CNT_OUT_W-1:0] on_list;
    logic [CNT_OUT_W-1:0] fresh;
  } grant_t;

  // Model copy of the pool
  logic [HANDLE_W-1:0]    handle_stack [STACK_DEPTH];
  int unsigned            stack_top;
  int unsigned            bump_bar;
  int unsigned            bump_slot;
  int unsigned            live_blocks;
  int unsigned            fresh_count;
  logic [BAR_COUNT_W-1:0] bar_count_q;
  logic [BAR_WIDTH_W-1:0] bar_width_q;

  grant_t expected_grants [$];
  grant_t seen;
  grant_t want;

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic grant_t serve_request(logic [IN_TDATA_W-1:0] word);
    grant_t              g;
    op_e                 op;
    logic [BAR_W-1:0]    fb;
    logic [SLOT_W-1:0]   fs;
    logic [HANDLE_W-1:0] h;
    int unsigned         bars;
    int unsigned         width;
    int unsigned         nb;
    int unsigned         ns;
    op    = op_e'(word[1:0]);
    fb    = word[5:2];
    fs    = word[11:6];
    g     = '0;
    bars  = clamp(bar_count_q, MIN_BAR_COUNT, MAX_BARS);
    width = clamp(bar_width_q, MIN_BAR_WIDTH, MAX_WIDTH);
    g.status = STAT_OK;
    case (op)
      OP_GET: begin
        if (stack_top > 0) begin
          stack_top--;
          h      = handle_stack[stack_top];
          g.bar  = h[HANDLE_W-1:SLOT_W];
          g.slot = h[SLOT_W-1:0];
          live_blocks++;
        end else begin
          nb = bump_bar;
          ns = bump_slot;
          // bar full: continue at slot 0 of the next bar
          if (ns >= width) begin
            ns = 0;
            nb++;
          end
          if (nb >= bars) begin
            g.status = STAT_EXHAUSTED;
          end else begin
            g.bar     = nb[BAR_W-1:0];
            g.slot    = ns[SLOT_W-1:0];
            bump_bar  = nb;
            bump_slot = ns + 1;
            live_blocks++;
            fresh_count++;
          end
        end
      end
      OP_FREE: begin
        if (live_blocks == 0) begin
          g.status = STAT_OVERFREE;
        end else if (stack_top >= STACK_DEPTH) begin
          g.status = STAT_FULL;
        end else begin
          handle_stack[stack_top] = {fb, fs};
          stack_top++;
          live_blocks--;
        end
      end
      OP_CLEAR: begin
        stack_top   = 0;
        bump_bar    = 0;
        bump_slot   = 0;
        live_blocks = 0;
        fresh_count = 0;
      end
      default: ;
    endcase
    g.in_use  = live_blocks[CNT_OUT_W-1:0];
    g.on_list = stack_top[CNT_OUT_W-1:0];
    g.fresh   = fresh_count[CNT_OUT_W-1:0];
    return g;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned exp_val);
    fail_count_o++;
    if (fail_count_o <= MAX_PRINTS) begin
      $display("%0t: word %0d %s: got %0d, want %0d", $realtime, words_checked_o, field,
               got, exp_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_top       = 0;
      bump_bar        = 0;
      bump_slot       = 0;
      live_blocks     = 0;
      fresh_count     = 0;
      bar_count_q     = BAR_COUNT_RST;
      bar_width_q     = BAR_WIDTH_RST;
      fail_count_o    = 0;
      words_checked_o = 0;
      expected_grants.delete();
      pending_o      <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_BAR_COUNT) begin
          bar_count_q = cfg_data_i[BAR_COUNT_W-1:0];
        end else begin
          bar_width_q = cfg_data_i;
        end
      end
      if (out_valid_i && out_ready_i) begin
        seen.status  = status_e'(out_data_i[1:0]);
        seen.bar     = out_data_i[5:2];
        seen.slot    = out_data_i[11:6];
        seen.in_use  = out_data_i[22:12];
        seen.on_list = out_data_i[33:23];
        seen.fresh   = out_data_i[44:34];
        if (expected_grants.size() == 0) begin
          report_mismatch("arrived with nothing pending, status", seen.status, 0);
        end else begin
          want = expected_grants.pop_front();
          if (seen.status !== want.status)
            report_mismatch("status", seen.status, want.status);
          if (seen.bar !== want.bar)
            report_mismatch("bar_index", seen.bar, want.bar);
          if (seen.slot !== want.slot)
            report_mismatch("slot_index", seen.slot, want.slot);
          if (seen.in_use !== want.in_use)
            report_mismatch("in_use", seen.in_use, want.in_use);
          if (seen.on_list !== want.on_list)
            report_mismatch("on_list", seen.on_list, want.on_list);
          if (seen.fresh !== want.fresh)
            report_mismatch("fresh_taken", seen.fresh, want.fresh);
        end
        words_checked_o++;
      end
      if (in_valid_i && in_ready_i) begin
        expected_grants.push_back(serve_request(in_data_i));
      end
      pending_o <= expected_grants.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the pool allocator testbench: clock, reset, request and register
// stimulus, result-side backpressure and verdict. Needs fbpa_pkg and fbpa_checker.
module tb_top;
  import fbpa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 94;
  localparam int unsigned PHASES      = 8;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic                   cfg_index;
  logic [BAR_WIDTH_W-1:0] cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [IN_TDATA_W-1:0]  in_data;
  logic                   out_valid;
  logic                   out_ready;
  logic [OUT_TDATA_W-1:0] out_data;

  int fails;
  int pending;
  int words_checked;
  int sent_words  = 0;
  int settings    = 0;
  int cycle_cnt   = 0;
  bit quiet       = 1'b0;
  bit hold_long   = 1'b0;

  int unsigned count_plan [PHASES] = '{0, 31, 2, 16, 1, 17, 0, 0};
  int unsigned width_plan [PHASES] = '{0, 127, 5, 64, 4, 65, 0, 0};

  always #6 clk = ~clk;

  fixed_block_pool_allocator DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  fbpa_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_data_i      (out_data),
    .fail_count_o    (fails),
    .pending_o       (pending),
    .words_checked_o (words_checked)
  );

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_req(op_e op, logic [BAR_W-1:0] fb,
                                                     logic [SLOT_W-1:0] fs);
    logic [IN_TDATA_W-1:0] w;
    w       = '0;
    w[1:0]  = op;
    w[5:2]  = fb;
    w[11:6] = fs;
    return w;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] random_req(int unsigned get_pct);
    int unsigned r;
    op_e         op;
    r = $urandom_range(0, 99);
    if (r < get_pct)  op = OP_GET;
    else if (r < 94)  op = OP_FREE;
    else if (r < 97)  op = OP_CLEAR;
    else              op = OP_NONE;
    return pack_req(op, BAR_W'($urandom), SLOT_W'($urandom));
  endfunction

  // Offer one request word after a random gap; hold until accepted.
  task automatic send_word(logic [IN_TDATA_W-1:0] w);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_words++;
  endtask

  task automatic write_reg(logic idx, logic [BAR_WIDTH_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop the request side and wait until every expected result is back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random stall per word, plus one long hold on request.
  initial begin
    int unsigned stall;
    bit          hold_used;
    hold_used = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long && !hold_used) begin
        hold_used = 1'b1;
        stall     = HOLD_CYCLES;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  initial begin
    int unsigned get_pct;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_BAR_COUNT;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset geometry: fresh grants, LIFO reuse, over-free, no-op, clear
    send_word(pack_req(OP_GET, '0, '0));
    send_word(pack_req(OP_GET, '0, '0));
    send_word(pack_req(OP_FREE, 4'd15, 6'd63));
    send_word(pack_req(OP_GET, '0, '0));
    send_word(pack_req(OP_FREE, 4'd0, 6'd0));
    send_word(pack_req(OP_FREE, 4'd9, 6'd21));
    send_word(pack_req(OP_FREE, 4'd5, 6'd5));
    send_word(pack_req(OP_NONE, 4'd15, 6'd63));
    send_word(pack_req(OP_CLEAR, 4'd15, 6'd63));
    send_word(pack_req(OP_FREE, 4'd3, 6'd7));
    send_word(pack_req(OP_GET, '0, '0));
    drain_results();

    // Smallest pool: bar rollover, exhaustion, reuse of an unchecked handle
    write_reg(REG_BAR_COUNT, 7'd2);
    write_reg(REG_BAR_WIDTH, 7'd5);
    settings++;
    send_word(pack_req(OP_CLEAR, '0, '0));
    repeat (11) send_word(pack_req(OP_GET, '0, '0));
    send_word(pack_req(OP_FREE, 4'd10, 6'd42));
    send_word(pack_req(OP_GET, '0, '0));
    send_word(pack_req(OP_GET, '0, '0));

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_reg(REG_BAR_COUNT, (p >= 6) ? BAR_WIDTH_W'($urandom) : BAR_WIDTH_W'(count_plan[p]));
      write_reg(REG_BAR_WIDTH, (p >= 6) ? BAR_WIDTH_W'($urandom) : BAR_WIDTH_W'(width_plan[p]));
      settings++;
      quiet   = (p % 3 == 1);
      get_pct = (p == 1 || p == 3) ? 85 : 58;
      // hold the result side off for a long stall in this phase
      if (p == 2) hold_long = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == PHASE_ITEMS / 2) drain_results();
        send_word(random_req(get_pct));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d requests and %0d result words over %0d pool geometries",
             sent_words, words_checked, settings);
    $display("geometries included clamped register extremes and a long result-side hold");
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d field mismatches", fails);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
